@@ src/oed_pkg.sv @@
// ----------------------------------------------------------------------------
// oed_pkg
// Shared types and constants for the octal escape decoder.
// ----------------------------------------------------------------------------
package oed_pkg;

  localparam int LENGTH_BITS = 16;

  localparam logic [7:0] ESC_CHAR  = 8'h5C;
  localparam logic [7:0] DIGIT_LO  = 8'h30;
  localparam logic [7:0] DIGIT_HI  = 8'h37;
  localparam logic [8:0] MAX_OCTAL = 9'o377;

  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] COUNT_ONE = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_ESCAPE   = 2'd1;
  localparam logic [1:0] ERR_CAPACITY = 2'd2;

  typedef enum logic [1:0] {
    CLS_ESC,
    CLS_DIGIT,
    CLS_OTHER
  } char_class_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       last;
  } oed_in_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        end_of_record;
    logic [1:0]  status;
    logic [15:0] decoded_length;
  } oed_out_t;

  // Classified character as it travels from the front to the back.
  typedef struct packed {
    char_class_t cls;
    logic [7:0]  in_char;
    logic        last;
  } oed_token_t;

endpackage

@@ src/oed_front.sv @@
// ----------------------------------------------------------------------------
// oed_front
// Classifies each incoming character as backslash, octal digit or other.
// ----------------------------------------------------------------------------
module oed_front (
  input  oed_pkg::oed_in_t    item,
  output oed_pkg::oed_token_t token
);

  always_comb begin
    token.in_char = item.in_char;
    token.last    = item.last;
    if (item.in_char == oed_pkg::ESC_CHAR) begin
      token.cls = oed_pkg::CLS_ESC;
    end else if (item.in_char >= oed_pkg::DIGIT_LO && item.in_char <= oed_pkg::DIGIT_HI) begin
      token.cls = oed_pkg::CLS_DIGIT;
    end else begin
      token.cls = oed_pkg::CLS_OTHER;
    end
  end

endmodule

@@ src/oed_queue.sv @@
// ----------------------------------------------------------------------------
// oed_queue
// Two-entry token queue between the classifier and the decoder.
// ----------------------------------------------------------------------------
module oed_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  oed_pkg::oed_token_t wr_token,
  output logic                full,
  input  logic                rd_en,
  output logic                rd_valid,
  output oed_pkg::oed_token_t rd_token
);

  oed_pkg::oed_token_t slots [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                do_wr;
  logic                do_rd;

  assign do_wr    = wr_en && (count != 2'd2);
  assign do_rd    = rd_en && (count != 2'd0);
  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_token = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ src/oed_back.sv @@
// ----------------------------------------------------------------------------
// oed_back
// Escape decoder state, byte counter, capacity check and result register.
// ----------------------------------------------------------------------------
module oed_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic                tok_valid,
  input  oed_pkg::oed_token_t tok,
  output logic                tok_take,
  output logic                res_valid,
  output oed_pkg::oed_out_t   res,
  input  logic                res_pop
);

  logic [15:0]                      out_capacity;
  logic [1:0]                       escape_phase;
  logic [1:0]                       escape_phase_next;
  logic [8:0]                       octal_value;
  logic [8:0]                       octal_value_next;
  logic [1:0]                       error_code;
  logic [1:0]                       error_code_next;
  logic [oed_pkg::LENGTH_BITS-1:0]  byte_count;
  logic [oed_pkg::LENGTH_BITS-1:0]  byte_count_next;
  logic                             have;
  logic [7:0]                       byte_val;
  logic                             emit;
  logic [31:0]                      count_wide;
  logic [15:0]                      len;
  oed_pkg::oed_out_t                res_next;

  // A token is consumed whenever the result register is free or draining.
  assign tok_take = tok_valid && (!res_valid || res_pop);

  always_comb begin
    escape_phase_next = escape_phase;
    octal_value_next  = octal_value;
    error_code_next   = error_code;
    byte_count_next   = byte_count;
    have              = 1'b0;
    byte_val          = 8'd0;

    if (error_code != oed_pkg::ERR_ESCAPE) begin
      if (escape_phase == 2'd0) begin
        if (tok.cls == oed_pkg::CLS_ESC) begin
          escape_phase_next = 2'd1;
          octal_value_next  = 9'd0;
        end else begin
          have     = 1'b1;
          byte_val = tok.in_char;
        end
      end else if (tok.cls != oed_pkg::CLS_DIGIT) begin
        error_code_next   = oed_pkg::ERR_ESCAPE;
        escape_phase_next = 2'd0;
      end else begin
        octal_value_next = {octal_value[5:0], tok.in_char[2:0]};
        if (escape_phase == 2'd3) begin
          escape_phase_next = 2'd0;
          if (octal_value_next > oed_pkg::MAX_OCTAL) begin
            error_code_next = oed_pkg::ERR_ESCAPE;
          end else begin
            have     = 1'b1;
            byte_val = octal_value_next[7:0];
          end
        end else begin
          escape_phase_next = escape_phase + 2'd1;
        end
      end

      if (have) begin
        if (byte_count == oed_pkg::COUNT_MAX) begin
          error_code_next = oed_pkg::ERR_CAPACITY;
        end else begin
          byte_count_next = byte_count + oed_pkg::COUNT_ONE;
          if (32'(byte_count_next) > 32'(out_capacity)) begin
            error_code_next = oed_pkg::ERR_CAPACITY;
          end
        end
        if (error_code_next != oed_pkg::ERR_NONE) begin
          have = 1'b0;
        end
      end

      if (tok.last && escape_phase_next != 2'd0) begin
        error_code_next = oed_pkg::ERR_ESCAPE;
      end
    end

    emit       = tok.last || have;
    count_wide = 32'(byte_count_next);
    len        = (count_wide > 32'hFFFF) ? 16'hFFFF : count_wide[15:0];

    res_next.data_byte      = have ? byte_val : 8'd0;
    res_next.byte_valid     = have;
    res_next.end_of_record  = tok.last;
    res_next.status         = tok.last ? error_code_next : oed_pkg::ERR_NONE;
    res_next.decoded_length = len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= 16'hFFFF;
    end else if (cfg_we) begin
      out_capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_phase <= 2'd0;
      octal_value  <= 9'd0;
      error_code   <= oed_pkg::ERR_NONE;
      byte_count   <= '0;
    end else if (tok_take) begin
      if (tok.last) begin
        escape_phase <= 2'd0;
        octal_value  <= 9'd0;
        error_code   <= oed_pkg::ERR_NONE;
        byte_count   <= '0;
      end else begin
        escape_phase <= escape_phase_next;
        octal_value  <= octal_value_next;
        error_code   <= error_code_next;
        byte_count   <= byte_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (tok_take) begin
      res_valid <= emit;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_take && emit) begin
      res <= res_next;
    end
  end

endmodule

@@ src/octal_escape_decoder_core.sv @@
// A pushed character is held in the token queue, then decoded into the result register.
// Throughput: one character per cycle, sustained while results are popped.
// A two-entry token queue separates intake from decoding, and a one-entry
// result register separates decoding from the consumer.
// Reset (rst, synchronous) empties both queues, clears the record state and
// sets out_capacity to 65535.
// ----------------------------------------------------------------------------
// octal_escape_decoder_core
// Streams decoded bytes of backslash-octal escaped records with status.
// ----------------------------------------------------------------------------
module octal_escape_decoder_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  oed_pkg::oed_in_t  in_item,
  output logic              empty,
  input  logic              pop,
  output oed_pkg::oed_out_t out_item,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data
);

  oed_pkg::oed_token_t front_token;
  oed_pkg::oed_token_t head_token;
  logic                head_valid;
  logic                head_take;
  logic                res_valid;

  oed_front u_front (
    .item  (in_item),
    .token (front_token)
  );

  oed_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_token (front_token),
    .full     (full),
    .rd_en    (head_take),
    .rd_valid (head_valid),
    .rd_token (head_token)
  );

  oed_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .tok_valid (head_valid),
    .tok       (head_token),
    .tok_take  (head_take),
    .res_valid (res_valid),
    .res       (out_item),
    .res_pop   (pop)
  );

  assign empty = !res_valid;

endmodule
